@@ design/fpas_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fpas_pkg
// Shared types and constants of the binary32/binary64 adder.
// ----------------------------------------------------------------------------
package fpas_pkg;

    localparam int FRAME_W = 56;
    localparam int SIG_W   = 53;
    localparam int EXP_W   = 11;
    localparam int EXPX_W  = 12;
    localparam int GRP_N   = 7;
    localparam int LZ_W    = 6;

    localparam logic [EXP_W-1:0]  EXP_ONES_D    = 11'h7ff;
    localparam logic [7:0]        EXP_ONES_S    = 8'hff;
    localparam logic [EXPX_W-1:0] EXP_LIMIT_D   = 12'd2047;
    localparam logic [EXPX_W-1:0] EXP_LIMIT_S   = 12'd255;
    localparam logic [63:0]       DEFAULT_NAN_D = 64'h7ff8_0000_0000_0000;
    localparam logic [63:0]       DEFAULT_NAN_S = 64'h0000_0000_7fc0_0000;
    localparam logic [63:0]       QUIET_D       = 64'h0008_0000_0000_0000;
    localparam logic [63:0]       QUIET_S       = 64'h0000_0000_0040_0000;

    typedef struct packed {
        logic inv;
        logic ovf;
        logic unf;
        logic inx;
    } fpas_flags_t;

    typedef struct packed {
        logic        dbl;
        logic        byp;
        logic [63:0] byp_bits;
        logic        byp_inv;
        logic        sign;
    } fpas_ctl_t;

    typedef struct packed {
        fpas_ctl_t        ctl;
        logic             eff_sub;
        logic [EXP_W-1:0] exp_big;
        logic [EXP_W-1:0] exp_sml;
        logic [SIG_W-1:0] sig_big;
        logic [SIG_W-1:0] sig_sml;
    } fpas_op_t;

endpackage
`default_nettype wire

@@ design/fpas_front.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fpas_front
// Unpacks and classifies both operands, settles special cases and orders
// the operands by magnitude for the arithmetic pipeline.
// ----------------------------------------------------------------------------
module fpas_front
    import fpas_pkg::*;
(
    input  logic        req_type,
    input  logic        is_double,
    input  logic [63:0] operand_a,
    input  logic [63:0] operand_b,
    output fpas_op_t    op
);

    logic [63:0]      af;
    logic [63:0]      bf;
    logic             sa;
    logic             sb;
    logic [EXP_W-1:0] ea;
    logic [EXP_W-1:0] eb;
    logic [51:0]      fa;
    logic [51:0]      fb;
    logic             ones_a;
    logic             ones_b;
    logic             nan_a;
    logic             nan_b;
    logic             snan_a;
    logic             snan_b;
    logic             inf_a;
    logic             inf_b;
    logic             zero_a;
    logic             zero_b;
    logic             a_big;
    logic [63:0]      quiet;
    logic [63:0]      dnan;
    logic [EXP_W-1:0] xa;
    logic [EXP_W-1:0] xb;

    assign af = is_double ? operand_a : {32'b0, operand_a[31:0]};
    assign bf = is_double ? {operand_b[63] ^ req_type, operand_b[62:0]}
                          : {32'b0, operand_b[31] ^ req_type, operand_b[30:0]};

    assign sa = is_double ? af[63] : af[31];
    assign sb = is_double ? bf[63] : bf[31];
    assign ea = is_double ? af[62:52] : {3'b0, af[30:23]};
    assign eb = is_double ? bf[62:52] : {3'b0, bf[30:23]};
    assign fa = is_double ? af[51:0] : {af[22:0], 29'b0};
    assign fb = is_double ? bf[51:0] : {bf[22:0], 29'b0};

    assign ones_a = is_double ? (ea == EXP_ONES_D) : (ea[7:0] == EXP_ONES_S);
    assign ones_b = is_double ? (eb == EXP_ONES_D) : (eb[7:0] == EXP_ONES_S);
    assign nan_a  = ones_a && (fa != '0);
    assign nan_b  = ones_b && (fb != '0);
    assign snan_a = nan_a && !fa[51];
    assign snan_b = nan_b && !fb[51];
    assign inf_a  = ones_a && (fa == '0);
    assign inf_b  = ones_b && (fb == '0);
    assign zero_a = (ea == '0) && (fa == '0);
    assign zero_b = (eb == '0) && (fb == '0);

    assign a_big = {ea, fa} >= {eb, fb};
    assign quiet = is_double ? QUIET_D : QUIET_S;
    assign dnan  = is_double ? DEFAULT_NAN_D : DEFAULT_NAN_S;
    assign xa    = (ea == '0) ? EXP_W'(1) : ea;
    assign xb    = (eb == '0) ? EXP_W'(1) : eb;

    always_comb
    begin
        op.ctl.dbl      = is_double;
        op.ctl.byp      = 1'b1;
        op.ctl.byp_inv  = 1'b0;
        op.ctl.byp_bits = '0;
        op.ctl.sign     = a_big ? sa : sb;
        op.eff_sub      = sa ^ sb;
        op.exp_big      = a_big ? xa : xb;
        op.exp_sml      = a_big ? xb : xa;
        op.sig_big      = a_big ? {ea != '0, fa} : {eb != '0, fb};
        op.sig_sml      = a_big ? {eb != '0, fb} : {ea != '0, fa};
        priority if (nan_a || nan_b)
        begin
            op.ctl.byp_bits = (nan_a ? af : bf) | quiet;
            op.ctl.byp_inv  = snan_a || snan_b;
        end
        else if (inf_a && inf_b && (sa != sb))
        begin
            op.ctl.byp_bits = dnan;
            op.ctl.byp_inv  = 1'b1;
        end
        else if (inf_a)
        begin
            op.ctl.byp_bits = af;
        end
        else if (inf_b)
        begin
            op.ctl.byp_bits = bf;
        end
        else if (zero_a && zero_b)
        begin
            op.ctl.byp_bits = (sa == sb) ? af : '0;
        end
        else if (zero_a)
        begin
            op.ctl.byp_bits = bf;
        end
        else if (zero_b)
        begin
            op.ctl.byp_bits = af;
        end
        else
        begin
            op.ctl.byp = 1'b0;
        end
    end

endmodule
`default_nettype wire

@@ design/fpas_queue.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fpas_queue
// Short queue of classified words between front and arithmetic pipeline.
// ----------------------------------------------------------------------------
module fpas_queue
    import fpas_pkg::*;
#(
    parameter int DEPTH = 4
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     push_valid,
    output logic     push_ready,
    input  fpas_op_t push_op,
    output logic     pop_valid,
    input  logic     pop_ready,
    output fpas_op_t pop_op
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    fpas_op_t         mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;
    logic             push;
    logic             pop;

    assign push_ready = cnt_reg != CNT_W'(DEPTH);
    assign pop_valid  = cnt_reg != '0;
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;
    assign pop_op     = mem_reg[rd_ptr_reg];

    assign wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
    assign rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;

    always_comb
    begin
        cnt_next = cnt_reg;
        if (push && !pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_next;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_op;
        end
    end

endmodule
`default_nettype wire

@@ design/fpas_back.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fpas_back
// Six-stage arithmetic pipeline: align, add, leading-zero groups,
// shift amount, normalise, round and pack into the output register.
// ----------------------------------------------------------------------------
module fpas_back
    import fpas_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  fpas_op_t    op,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [63:0] sum_bits,
    output fpas_flags_t flags
);

    function automatic logic [2:0] lz8(input logic [7:0] x);
        logic [2:0] res;
        res = '0;
        for (int i = 0; i < 8; i++)
        begin
            if (x[i])
            begin
                res = 3'(7 - i);
            end
        end
        return res;
    endfunction

    logic [5:0] vld_reg;
    logic [5:0] rdy;

    // stage registers
    fpas_ctl_t          ctl1_reg, ctl2_reg, ctl3_reg, ctl4_reg, ctl5_reg;
    logic               sub1_reg;
    logic [EXP_W-1:0]   exp1_reg, exp2_reg;
    logic [FRAME_W-1:0] xs1_reg, ys1_reg;
    logic [FRAME_W:0]   r2_reg;
    logic [FRAME_W-1:0] n3_reg, n4_reg, n5_reg;
    logic [EXPX_W-1:0]  e3_reg, e4_reg, e5_reg;
    logic               zero3_reg, zero4_reg, zero5_reg;
    logic [GRP_N-1:0]   gnz3_reg;
    logic [2:0]         glz3_reg [GRP_N];
    logic [LZ_W-1:0]    amt4_reg;
    logic [63:0]        sum_reg;
    fpas_flags_t        flags_reg;

    // next values
    logic [EXP_W-1:0]   d;
    logic [FRAME_W-1:0] ysrc;
    logic [FRAME_W-1:0] mask;
    logic [FRAME_W-1:0] ys1_next;
    logic [FRAME_W:0]   r2_next;
    logic [FRAME_W-1:0] n3_next;
    logic [EXPX_W-1:0]  e3_next;
    logic [GRP_N-1:0]   gnz3_next;
    logic [2:0]         glz3_next [GRP_N];
    logic [LZ_W-1:0]    lz;
    logic [EXPX_W-1:0]  emin1;
    logic [LZ_W-1:0]    amt4_next;
    logic [63:0]        sum_next;
    fpas_flags_t        flags_next;

    // rounding
    logic [SIG_W-1:0]   q;
    logic               g;
    logic               rs;
    logic               up;
    logic [SIG_W:0]     qr;
    logic               carry;
    logic               hid;
    logic [EXPX_W-1:0]  e6;
    logic               ovf;
    logic               inx;
    logic [51:0]        frac;

    always_comb
    begin
        rdy[5] = !vld_reg[5] || out_ready;
        rdy[4] = !vld_reg[4] || rdy[5];
        rdy[3] = !vld_reg[3] || rdy[4];
        rdy[2] = !vld_reg[2] || rdy[3];
        rdy[1] = !vld_reg[1] || rdy[2];
        rdy[0] = !vld_reg[0] || rdy[1];
    end

    assign in_ready  = rdy[0];
    assign out_valid = vld_reg[5];
    assign sum_bits  = sum_reg;
    assign flags     = flags_reg;

    // align with sticky
    assign d    = op.exp_big - op.exp_sml;
    assign ysrc = {op.sig_sml, 3'b0};
    assign mask = ~({FRAME_W{1'b1}} << d[LZ_W-1:0]);

    always_comb
    begin
        if (d >= EXP_W'(FRAME_W))
        begin
            ys1_next = {{(FRAME_W-1){1'b0}}, |ysrc};
        end
        else
        begin
            ys1_next = (ysrc >> d[LZ_W-1:0])
                       | {{(FRAME_W-1){1'b0}}, |(ysrc & mask)};
        end
    end

    // add
    assign r2_next = sub1_reg ? ({1'b0, xs1_reg} - {1'b0, ys1_reg})
                              : ({1'b0, xs1_reg} + {1'b0, ys1_reg});

    // carry fold and leading-zero groups
    assign n3_next = r2_reg[FRAME_W] ? {r2_reg[FRAME_W:2], r2_reg[1] | r2_reg[0]}
                                     : r2_reg[FRAME_W-1:0];
    assign e3_next = {1'b0, exp2_reg} + EXPX_W'(r2_reg[FRAME_W]);

    always_comb
    begin
        for (int k = 0; k < GRP_N; k++)
        begin
            gnz3_next[k] = |n3_next[FRAME_W-1-8*k -: 8];
            glz3_next[k] = lz8(n3_next[FRAME_W-1-8*k -: 8]);
        end
    end

    // shift amount, held at the subnormal boundary
    always_comb
    begin
        lz = LZ_W'(FRAME_W);
        for (int k = GRP_N - 1; k >= 0; k--)
        begin
            if (gnz3_reg[k])
            begin
                lz = LZ_W'(8 * k) + LZ_W'(glz3_reg[k]);
            end
        end
    end

    assign emin1     = e3_reg - 1'b1;
    assign amt4_next = ({{(EXPX_W-LZ_W){1'b0}}, lz} < emin1) ? lz : emin1[LZ_W-1:0];

    // round to nearest even and pack
    always_comb
    begin
        if (ctl5_reg.dbl)
        begin
            q  = n5_reg[FRAME_W-1:3];
            g  = n5_reg[2];
            rs = |n5_reg[1:0];
        end
        else
        begin
            q  = {29'b0, n5_reg[FRAME_W-1:32]};
            g  = n5_reg[31];
            rs = |n5_reg[30:0];
        end
        up    = g && (rs || q[0]);
        qr    = {1'b0, q} + (SIG_W+1)'(up);
        carry = ctl5_reg.dbl ? qr[53] : qr[24];
        hid   = ctl5_reg.dbl ? qr[52] : qr[23];
        e6    = e5_reg + EXPX_W'(carry);
        ovf   = e6 >= (ctl5_reg.dbl ? EXP_LIMIT_D : EXP_LIMIT_S);
        inx   = g || rs || ovf;
        frac  = carry ? '0 : qr[51:0];

        flags_next = '0;
        sum_next   = '0;
        priority if (ctl5_reg.byp)
        begin
            sum_next       = ctl5_reg.byp_bits;
            flags_next.inv = ctl5_reg.byp_inv;
        end
        else if (zero5_reg)
        begin
            sum_next = '0;
        end
        else if (ovf)
        begin
            flags_next.ovf = 1'b1;
            flags_next.inx = 1'b1;
            sum_next = ctl5_reg.dbl ? {ctl5_reg.sign, EXP_ONES_D, 52'b0}
                                    : {32'b0, ctl5_reg.sign, EXP_ONES_S, 23'b0};
        end
        else
        begin
            flags_next.inx = inx;
            flags_next.unf = !(carry || hid) && (g || rs);
            if (ctl5_reg.dbl)
            begin
                sum_next = {ctl5_reg.sign, (carry || hid) ? e6[10:0] : 11'b0, frac};
            end
            else
            begin
                sum_next = {32'b0, ctl5_reg.sign, (carry || hid) ? e6[7:0] : 8'b0,
                            frac[22:0]};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            if (rdy[0])
            begin
                vld_reg[0] <= in_valid;
            end
            for (int k = 1; k < 6; k++)
            begin
                if (rdy[k])
                begin
                    vld_reg[k] <= vld_reg[k-1];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy[0])
        begin
            ctl1_reg <= op.ctl;
            sub1_reg <= op.eff_sub;
            exp1_reg <= op.exp_big;
            xs1_reg  <= {op.sig_big, 3'b0};
            ys1_reg  <= ys1_next;
        end
        if (rdy[1])
        begin
            ctl2_reg <= ctl1_reg;
            exp2_reg <= exp1_reg;
            r2_reg   <= r2_next;
        end
        if (rdy[2])
        begin
            ctl3_reg  <= ctl2_reg;
            n3_reg    <= n3_next;
            e3_reg    <= e3_next;
            zero3_reg <= r2_reg == '0;
            gnz3_reg  <= gnz3_next;
            glz3_reg  <= glz3_next;
        end
        if (rdy[3])
        begin
            ctl4_reg  <= ctl3_reg;
            n4_reg    <= n3_reg;
            zero4_reg <= zero3_reg;
            amt4_reg  <= amt4_next;
            e4_reg    <= e3_reg - EXPX_W'(amt4_next);
        end
        if (rdy[4])
        begin
            ctl5_reg  <= ctl4_reg;
            n5_reg    <= n4_reg << amt4_reg;
            e5_reg    <= e4_reg;
            zero5_reg <= zero4_reg;
        end
        if (rdy[5])
        begin
            sum_reg   <= sum_next;
            flags_reg <= flags_next;
        end
    end

endmodule
`default_nettype wire

@@ design/fp_add_sub_binary32_binary64.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fp_add_sub_binary32_binary64
// IEEE 754 binary32/binary64 adder and subtractor, round to nearest even.
// ----------------------------------------------------------------------------
// One word is accepted and one result leaves per cycle unless the output side
// stalls. A word is written into the input queue, aligned straight out of it,
// then added, put through leading-zero groups, shift amount and normalise,
// and rounded into the output register. The input queue holds QUEUE_DEPTH
// words, so the front keeps accepting while the output side stalls until it fills.
module fp_add_sub_binary32_binary64
    import fpas_pkg::*;
#(
    parameter int QUEUE_DEPTH = 4
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        req_type,
    input  logic        is_double,
    input  logic [63:0] operand_a,
    input  logic [63:0] operand_b,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [63:0] sum_bits,
    output logic        flag_invalid,
    output logic        flag_overflow,
    output logic        flag_underflow,
    output logic        flag_inexact
);

    fpas_op_t    front_op;
    fpas_op_t    queue_op;
    logic        queue_valid;
    logic        back_ready;
    fpas_flags_t flags;

    fpas_front u_front
    (
        .req_type  (req_type),
        .is_double (is_double),
        .operand_a (operand_a),
        .operand_b (operand_b),
        .op        (front_op)
    );

    fpas_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (in_valid),
        .push_ready (in_ready),
        .push_op    (front_op),
        .pop_valid  (queue_valid),
        .pop_ready  (back_ready),
        .pop_op     (queue_op)
    );

    fpas_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (queue_valid),
        .in_ready  (back_ready),
        .op        (queue_op),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .sum_bits  (sum_bits),
        .flags     (flags)
    );

    assign flag_invalid   = flags.inv;
    assign flag_overflow  = flags.ovf;
    assign flag_underflow = flags.unf;
    assign flag_inexact   = flags.inx;

endmodule
`default_nettype wire

@@ design/fpas_checker.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fpas_checker
// Port-level checks of the adder, bound to the top level.
// ----------------------------------------------------------------------------
module fpas_checker
(
    input wire        clk,
    input wire        rst_n,
    input wire        out_valid,
    input wire        out_ready,
    input wire [63:0] sum_bits,
    input wire        flag_invalid,
    input wire        flag_overflow,
    input wire        flag_underflow,
    input wire        flag_inexact
);

    // stalled result word holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(sum_bits))
        else $error("result changed while stalled");

    a_ovf_inx: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && flag_overflow |-> flag_inexact)
        else $error("overflow without inexact");

    a_unf_inx: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && flag_underflow |-> flag_inexact && !flag_overflow)
        else $error("underflow flags inconsistent");

    a_inv_only: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && flag_invalid |-> !flag_overflow && !flag_underflow && !flag_inexact)
        else $error("invalid with rounding flags");

endmodule

bind fp_add_sub_binary32_binary64 fpas_checker u_fpas_checker (.*);
`default_nettype wire

@@ dv/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Checks the binary32/binary64 adder against a bit-exact software adder.
// Directed corner words, then random words biased to hit near-cancellation,
// subnormals and special values, under two patterns of random back-pressure and one with none.
// ----------------------------------------------------------------------------
module testbench;

    typedef struct {
        logic        sub;
        logic        dbl;
        logic [63:0] a;
        logic [63:0] b;
    } add_word_t;

    typedef struct {
        logic [63:0] bits;
        logic        inv;
        logic        ovf;
        logic        unf;
        logic        inx;
    } sum_word_t;

    localparam int WATCHDOG_LIMIT = 2000;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic        req_type;
    logic        is_double;
    logic [63:0] operand_a;
    logic [63:0] operand_b;
    logic        out_valid;
    logic        out_ready;
    logic [63:0] sum_bits;
    logic        flag_invalid;
    logic        flag_overflow;
    logic        flag_underflow;
    logic        flag_inexact;

    add_word_t pending_words[$];
    sum_word_t expected_sums[$];
    int        mismatch_count;
    int        idle_in_pct;
    int        idle_out_pct;
    int        quiet_cycles;
    bit        hold_sender;
    bit        accepted_in;

    fp_add_sub_binary32_binary64 dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .req_type       (req_type),
        .is_double      (is_double),
        .operand_a      (operand_a),
        .operand_b      (operand_b),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .sum_bits       (sum_bits),
        .flag_invalid   (flag_invalid),
        .flag_overflow  (flag_overflow),
        .flag_underflow (flag_underflow),
        .flag_inexact   (flag_inexact)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    function automatic logic [63:0] jam_shift(logic [63:0] v, int d);
        logic [63:0] lost;
        if (d == 0)
            return v;
        if (d >= 64)
            return {63'd0, v != 0};
        lost = v << (64 - d);
        return (v >> d) | {63'd0, lost != 0};
    endfunction

    // finite nonzero sum, rounded to nearest even
    function automatic logic [63:0] round_sum(logic sgn, int ex, logic [63:0] sig, int fb,
                                              int eb, int bias, ref sum_word_t r);
        logic [63:0] hid;
        logic [63:0] q;
        logic [63:0] grs;
        int          emin;
        logic [63:0] sbit;
        hid  = 64'd1 << fb;
        emin = 1 - bias;
        sbit = {63'd0, sgn} << (fb + eb);
        while (sig >= (hid << 4))
        begin
            sig = jam_shift(sig, 1);
            ex++;
        end
        while (sig < (hid << 3) && ex > emin)
        begin
            sig = sig << 1;
            ex--;
        end
        if (ex < emin)
        begin
            sig = jam_shift(sig, emin - ex);
            ex  = emin;
        end
        grs = sig & 64'd7;
        q   = sig >> 3;
        if (grs > 4 || (grs == 4 && q[0]))
            q++;
        if (grs != 0)
            r.inx = 1'b1;
        if (q >= (hid << 1))
        begin
            q = q >> 1;
            ex++;
        end
        if (ex > bias)
        begin
            r.ovf = 1'b1;
            r.inx = 1'b1;
            return sbit | (((64'd1 << eb) - 1) << fb);
        end
        if (ex == emin && q < hid)
        begin
            if (grs != 0)
                r.unf = 1'b1;
            return sbit | (q & (hid - 1));
        end
        return sbit | (64'(ex + bias) << fb) | (q & (hid - 1));
    endfunction

    function automatic sum_word_t predict_sum(add_word_t w);
        sum_word_t   r;
        int          fb;
        int          eb;
        int          bias;
        logic [63:0] a;
        logic [63:0] b;
        logic [63:0] fm;
        logic [63:0] em;
        logic [63:0] qb;
        logic [63:0] all;
        logic [63:0] ea;
        logic [63:0] eb_f;
        logic [63:0] fa;
        logic [63:0] fbb;
        logic        sa;
        logic        sb;
        logic        nan_a;
        logic        nan_b;
        int          xa;
        int          xb;
        int          d;
        logic [63:0] tmp;
        int          ti;
        logic        ts;
        logic [63:0] xs;
        logic [63:0] ys;
        logic [63:0] s;
        r    = '{64'd0, 1'b0, 1'b0, 1'b0, 1'b0};
        fb   = w.dbl ? 52 : 23;
        eb   = w.dbl ? 11 : 8;
        bias = w.dbl ? 1023 : 127;
        fm   = (64'd1 << fb) - 1;
        em   = (64'd1 << eb) - 1;
        qb   = 64'd1 << (fb - 1);
        all  = w.dbl ? '1 : 64'hffff_ffff;
        a    = w.a & all;
        b    = w.b & all;
        if (w.sub)
            b = b ^ (64'd1 << (fb + eb));
        ea    = (a >> fb) & em;
        eb_f  = (b >> fb) & em;
        fa    = a & fm;
        fbb   = b & fm;
        sa    = a[fb + eb];
        sb    = b[fb + eb];
        nan_a = ea == em && fa != 0;
        nan_b = eb_f == em && fbb != 0;
        if (nan_a || nan_b)
        begin
            r.inv  = (nan_a && (a & qb) == 0) || (nan_b && (b & qb) == 0);
            r.bits = ((nan_a ? a : b) | qb) & all;
            return r;
        end
        if (ea == em || eb_f == em)
        begin
            if (ea == em && eb_f == em && sa != sb)
            begin
                r.inv  = 1'b1;
                r.bits = (em << fb) | qb;
            end
            else
                r.bits = ea == em ? a : b;
            return r;
        end
        if (ea == 0 && fa == 0)
        begin
            if (eb_f == 0 && fbb == 0)
                r.bits = sa == sb ? a : 64'd0;
            else
                r.bits = b;
            return r;
        end
        if (eb_f == 0 && fbb == 0)
        begin
            r.bits = a;
            return r;
        end
        xa = ea == 0 ? 1 - bias : int'(ea) - bias;
        xb = eb_f == 0 ? 1 - bias : int'(eb_f) - bias;
        if (ea != 0)
            fa |= 64'd1 << fb;
        if (eb_f != 0)
            fbb |= 64'd1 << fb;
        while (fa < (64'd1 << fb))
        begin
            fa = fa << 1;
            xa--;
        end
        while (fbb < (64'd1 << fb))
        begin
            fbb = fbb << 1;
            xb--;
        end
        if (xa < xb || (xa == xb && fa < fbb))
        begin
            tmp = fa; fa = fbb; fbb = tmp;
            ti  = xa; xa = xb;  xb  = ti;
            ts  = sa; sa = sb;  sb  = ts;
        end
        d  = xa - xb;
        xs = fa << 3;
        ys = jam_shift(fbb << 3, d);
        if (sa == sb)
            s = xs + ys;
        else
        begin
            s = xs - ys;
            if (s == 0)
                return r;
        end
        r.bits = round_sum(sa, xa, s, fb, eb, bias, r) & all;
        return r;
    endfunction

    function automatic logic [63:0] random_operand(logic dbl);
        logic [63:0] v;
        int          fb;
        int          eb;
        v  = {$urandom, $urandom};
        fb = dbl ? 52 : 23;
        eb = dbl ? 11 : 8;
        case ($urandom_range(0, 9))
            0: v = v & ~(((64'd1 << eb) - 1) << fb);
            1: v = v | (((64'd1 << eb) - 1) << fb);
            2: v = v & ~((64'd1 << fb) - 1);
            3: v = (v & ~(((64'd1 << eb) - 1) << fb)) | (64'($urandom_range(1, 3)) << fb);
            4: v = (v & ~(((64'd1 << eb) - 1) << fb))
                   | (64'((1 << eb) - 1 - $urandom_range(1, 3)) << fb);
            default: ;
        endcase
        return v;
    endfunction

    task automatic queue_word(logic sub, logic dbl, logic [63:0] a, logic [63:0] b);
        add_word_t w;
        w.sub = sub;
        w.dbl = dbl;
        w.a   = a;
        w.b   = b;
        pending_words.push_back(w);
    endtask

    task automatic queue_random(int n);
        logic        dbl;
        logic [63:0] a;
        logic [63:0] b;
        for (int i = 0; i < n; i++)
        begin
            dbl = $urandom_range(0, 1);
            a   = random_operand(dbl);
            b   = random_operand(dbl);
            // near-cancellation: b close to a
            if ($urandom_range(0, 3) == 0)
                b = a ^ 64'($urandom_range(0, 15));
            queue_word($urandom_range(0, 1), dbl, a, b);
        end
    endtask

    initial
    begin
        in_valid  = 1'b0;
        out_ready = 1'b0;
        req_type  = 1'b0;
        is_double = 1'b0;
        operand_a = '0;
        operand_b = '0;
    end

    // driver: drives the head of the queue, the head leaves on acceptance
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            out_ready <= ($urandom_range(0, 99) >= idle_out_pct);
            if (!in_valid || accepted_in)
            begin
                if (pending_words.size() > 0 && !hold_sender
                    && $urandom_range(0, 99) >= idle_in_pct)
                begin
                    in_valid  <= 1'b1;
                    req_type  <= pending_words[0].sub;
                    is_double <= pending_words[0].dbl;
                    operand_a <= pending_words[0].a;
                    operand_b <= pending_words[0].b;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    always @(posedge clk)
    begin
        accepted_in <= 1'b0;
        if (rst_n && in_valid && in_ready)
        begin
            add_word_t w;
            w.sub = req_type;
            w.dbl = is_double;
            w.a   = operand_a;
            w.b   = operand_b;
            expected_sums.push_back(predict_sum(w));
            void'(pending_words.pop_front());
            accepted_in <= 1'b1;
        end
    end

    // monitor
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            sum_word_t e;
            if (expected_sums.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected result %h", sum_bits);
            end
            else
            begin
                e = expected_sums.pop_front();
                if (sum_bits !== e.bits || flag_invalid !== e.inv
                    || flag_overflow !== e.ovf || flag_underflow !== e.unf
                    || flag_inexact !== e.inx)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("mismatch: expected %h ivuo=%b%b%b%b got %h ivuo=%b%b%b%b",
                                 e.bits, e.inv, e.ovf, e.unf, e.inx, sum_bits,
                                 flag_invalid, flag_overflow, flag_underflow,
                                 flag_inexact);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    task automatic drain();
        while (pending_words.size() > 0 || in_valid || expected_sums.size() > 0)
            @(posedge clk);
    endtask

    task automatic drain_results();
        while (in_valid || expected_sums.size() > 0)
            @(posedge clk);
    endtask

    initial
    begin
        mismatch_count = 0;
        hold_sender    = 1'b0;
        idle_in_pct    = 24;
        idle_out_pct   = 65;
        rst_n          = 1'b0;
        // directed corners
        queue_word(0, 0, 64'hdead_beef_3f80_0000, 64'h1234_5678_3f80_0000);
        queue_word(1, 0, 64'h3f80_0000, 64'h3f80_0000);
        queue_word(0, 0, 64'h8000_0000, 64'h8000_0000);
        queue_word(0, 0, 64'h0000_0000, 64'h8000_0000);
        queue_word(0, 0, 64'h0000_0000, 64'h4040_0000);
        queue_word(0, 0, 64'h7f80_0000, 64'hff80_0000);
        queue_word(1, 0, 64'h7f80_0000, 64'h7f80_0000);
        queue_word(0, 0, 64'hff80_0000, 64'h3f80_0000);
        queue_word(0, 0, 64'h7f80_0001, 64'h7fc0_0002);
        queue_word(0, 0, 64'h3f80_0000, 64'hff80_0005);
        queue_word(0, 0, 64'h7f7f_ffff, 64'h7f7f_ffff);
        queue_word(0, 0, 64'h0000_0001, 64'h0000_0001);
        queue_word(1, 0, 64'h0080_0000, 64'h007f_ffff);
        queue_word(0, 0, 64'h3f80_0000, 64'h3380_0000);
        queue_word(0, 0, 64'h3f80_0001, 64'h3380_0000);
        queue_word(0, 1, 64'h3ff0_0000_0000_0000, 64'h3ca0_0000_0000_0000);
        queue_word(1, 1, 64'h3ff0_0000_0000_0000, 64'h3ff0_0000_0000_0000);
        queue_word(0, 1, 64'h7fef_ffff_ffff_ffff, 64'h7fef_ffff_ffff_ffff);
        queue_word(0, 1, 64'h7ff0_0000_0000_0000, 64'hfff0_0000_0000_0000);
        queue_word(0, 1, 64'hfff4_0000_0000_0000, 64'h7ff8_0000_0000_0001);
        queue_word(0, 1, 64'h0000_0000_0000_0001, 64'h8000_0000_0000_0003);
        queue_word(1, 1, 64'h8000_0000_0000_0000, 64'h0000_0000_0000_0000);
        queue_word(0, 1, 64'hffff_ffff_ffff_ffff, 64'h0000_0000_0000_0000);
        queue_word(1, 1, 64'h0010_0000_0000_0000, 64'h000f_ffff_ffff_ffff);
        queue_random(300);
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        drain();
        idle_in_pct  = 65;
        idle_out_pct = 24;
        queue_random(300);
        while (pending_words.size() > 150)
            @(posedge clk);
        // hold off the sender until every result is back
        hold_sender = 1'b1;
        drain_results();
        hold_sender = 1'b0;
        drain();
        idle_in_pct  = 0;
        idle_out_pct = 0;
        queue_random(300);
        drain();
        repeat (20) @(posedge clk);
        if (mismatch_count == 0 && expected_sums.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
